// File: src/gpio_port_pin_mode_interrupt_defines.svh
// Assertion macros for the GPIO port block.
`ifndef GPIO_PORT_PIN_MODE_INTERRUPT_DEFINES_SVH
`define GPIO_PORT_PIN_MODE_INTERRUPT_DEFINES_SVH
`ifndef SYNTH
`define GPPMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GPPMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GPPMI_ASSERT(label, prop, msg)
`define GPPMI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/gppmi_pkg.sv
// Shared types and codes for the GPIO port block.
package gppmi_pkg;

  localparam int NUM_PORTS_DEF = 4;
  localparam int MAX_PORTS     = 4;
  localparam int PIN_COUNT     = 8;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PIN   = 2'd2;

  localparam logic [2:0] REG_DATA = 3'd0;
  localparam logic [2:0] REG_DIR  = 3'd1;
  localparam logic [2:0] REG_ALT1 = 3'd2;
  localparam logic [2:0] REG_ALT2 = 3'd3;
  localparam logic [2:0] REG_MASK = 3'd4;

  typedef enum logic [2:0] {
    MODE_PASS      = 3'd0,
    MODE_LATCH     = 3'd1,
    MODE_COND_LAT  = 3'd2,
    MODE_HOLD_LAT  = 3'd3,
    MODE_EDGE      = 3'd4,
    MODE_OFF       = 3'd5,
    MODE_MATCH     = 3'd6,
    MODE_DIFF      = 3'd7
  } pin_mode_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] port;
    logic [2:0] reg_select;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] pin_result;
    logic       irq_valid;
    logic [7:0] irq_vector;
    logic       ack_request;
  } result_t;

  // One port's register set as seen by the execute logic
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] dir;
    logic [7:0] alt1;
    logic [7:0] alt2;
    logic [7:0] mask;
  } port_view_t;

  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_sel;
    logic [7:0] wr_val;
    logic       data_en;
    logic [7:0] data_val;
    logic       prev_en;
    logic [7:0] prev_val;
  } update_t;

endpackage

// File: src/gppmi_regs.sv
// Port register file plus the shared previous-level byte.
module gppmi_regs #(
  parameter int NUM_PORTS = gppmi_pkg::NUM_PORTS_DEF,
  parameter int PIW       = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PIW-1:0]       port_idx,
  input  logic                 commit,
  input  gppmi_pkg::update_t   upd,
  output gppmi_pkg::port_view_t view,
  output logic [7:0]           prev
);

  logic [7:0] data_r [NUM_PORTS];
  logic [7:0] dir_r  [NUM_PORTS];
  logic [7:0] alt1_r [NUM_PORTS];
  logic [7:0] alt2_r [NUM_PORTS];
  logic [7:0] mask_r [NUM_PORTS];
  logic [7:0] prev_r;

  assign view.data = data_r[port_idx];
  assign view.dir  = dir_r[port_idx];
  assign view.alt1 = alt1_r[port_idx];
  assign view.alt2 = alt2_r[port_idx];
  assign view.mask = mask_r[port_idx];
  assign prev      = prev_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        data_r[p] <= '0;
        dir_r[p]  <= '1;
        alt1_r[p] <= '0;
        alt2_r[p] <= '0;
        mask_r[p] <= '0;
      end
      prev_r <= '0;
    end else if (commit) begin
      if (upd.wr_en) begin
        unique case (upd.wr_sel)
          gppmi_pkg::REG_DATA: data_r[port_idx] <= upd.wr_val;
          gppmi_pkg::REG_DIR:  dir_r[port_idx]  <= upd.wr_val;
          gppmi_pkg::REG_ALT1: alt1_r[port_idx] <= upd.wr_val;
          gppmi_pkg::REG_ALT2: alt2_r[port_idx] <= upd.wr_val;
          gppmi_pkg::REG_MASK: mask_r[port_idx] <= upd.wr_val;
          default: ;
        endcase
      end
      if (upd.data_en) begin
        data_r[port_idx] <= upd.data_val;
      end
      if (upd.prev_en) begin
        prev_r <= upd.prev_val;
      end
    end
  end

endmodule

// File: src/gppmi_exec.sv
// Per-pin mode logic, interrupt pick, read mux and ack decode for one beat.
module gppmi_exec (
  input  gppmi_pkg::item_t      item,
  input  logic                  port_ok,
  input  gppmi_pkg::port_view_t view,
  input  logic [7:0]            prev,
  input  logic [7:0]            prio,
  output gppmi_pkg::result_t    res,
  output gppmi_pkg::update_t    upd
);

  logic [7:0] pins;
  logic [7:0] newd;
  logic [7:0] newprev;
  logic [7:0] trig;
  logic [7:0] ackp;
  logic [7:0] hi;
  logic [7:0] cand;
  logic [2:0] win;

  // Eight independent pin slices
  always_comb begin
    gppmi_pkg::pin_mode_t m;
    pins    = '0;
    newd    = view.data;
    newprev = prev;
    trig    = '0;
    ackp    = '0;
    for (int n = 0; n < gppmi_pkg::PIN_COUNT; n++) begin
      m = gppmi_pkg::pin_mode_t'({view.alt2[n], view.alt1[n], view.dir[n]});
      case (m) inside
        gppmi_pkg::MODE_PASS, gppmi_pkg::MODE_COND_LAT, gppmi_pkg::MODE_HOLD_LAT: ackp[n] = 1'b1;
        default: ;
      endcase
      unique case (m)
        gppmi_pkg::MODE_PASS:     pins[n] = item.data[n];
        gppmi_pkg::MODE_LATCH:    newd[n] = item.data[n];
        gppmi_pkg::MODE_COND_LAT: begin
          if (view.data[n]) newd[n] = item.data[n];
        end
        gppmi_pkg::MODE_HOLD_LAT: begin
          if (view.data[n]) pins[n] = 1'b1;
          else newd[n] = item.data[n];
        end
        gppmi_pkg::MODE_EDGE: begin
          if (view.data[n]) begin
            trig[n]    = item.data[n] & ~prev[n] & ~view.mask[n];
            newprev[n] = item.data[n];
          end
        end
        gppmi_pkg::MODE_OFF:   ;
        gppmi_pkg::MODE_MATCH: trig[n] = (item.data[n] == view.data[n]);
        gppmi_pkg::MODE_DIFF:  trig[n] = (item.data[n] != view.data[n]);
        default: ;
      endcase
    end
  end

  // Lowest high-priority trigger wins, else lowest trigger
  assign hi   = trig & prio;
  assign cand = (|hi) ? hi : trig;

  always_comb begin
    win = '0;
    for (int i = gppmi_pkg::PIN_COUNT - 1; i >= 0; i--) begin
      if (cand[i]) win = 3'(i);
    end
  end

  always_comb begin
    res = '0;
    upd = '0;
    upd.wr_sel   = item.reg_select;
    upd.wr_val   = item.data;
    upd.data_val = newd;
    upd.prev_val = newprev;
    if (port_ok) begin
      unique case (item.operation)
        gppmi_pkg::OP_WRITE: begin
          upd.wr_en       = 1'b1;
          res.ack_request = (item.reg_select == gppmi_pkg::REG_DATA) && (|ackp);
        end
        gppmi_pkg::OP_READ: begin
          unique case (item.reg_select)
            gppmi_pkg::REG_DATA: res.read_data = view.data;
            gppmi_pkg::REG_DIR:  res.read_data = view.dir;
            gppmi_pkg::REG_ALT1: res.read_data = view.alt1;
            gppmi_pkg::REG_ALT2: res.read_data = view.alt2;
            default:             res.read_data = '0;
          endcase
        end
        gppmi_pkg::OP_PIN: begin
          upd.data_en    = 1'b1;
          upd.prev_en    = 1'b1;
          res.pin_result = pins;
          res.irq_valid  = |trig;
          res.irq_vector = (|trig) ? {1'b1, item.port, win, 2'b00} : 8'h00;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/gpio_port_pin_mode_interrupt.sv
// Top level of the four-port GPIO block: beat pipeline, priority registers, checks.
//
//   channel  | dir | beat carries
//   s_axis   | in  | tuser: operation, port, reg_select; tdata: pin levels / write data
//   m_axis   | out | tdata: read_data, pin_result, irq_valid, irq_vector, ack_request
//   cfg      | in  | wen + index 0..3 + wdata: per-port interrupt priority bits
//
// Two register stages: an input register and a result register, with the pin logic,
// interrupt pick and register file update between them. One beat per cycle sustained
// while m_axis accepts; a beat is captured in the input register, then in the result register.
// State (data/previous levels) is updated when a beat moves into the result register,
// so the next beat always sees it. A stalled m_axis holds the input register full;
// s_axis_tready then drops. rst is synchronous: direction registers go to all ones,
// valid flags, the other port registers, the previous-level byte and priorities to zero.
`include "gpio_port_pin_mode_interrupt_defines.svh"
module gpio_port_pin_mode_interrupt #(
  parameter int NUM_PORTS = gppmi_pkg::NUM_PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data
  input  logic [6:0]  s_axis_tuser,   // [1:0] operation, [3:2] port, [6:4] reg_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] read_data, [15:8] pin_result,
                                      // [16] irq_valid, [24:17] irq_vector,
                                      // [25] ack_request, [31:26] zero
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int PIW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic                  in_valid;
  gppmi_pkg::item_t      in_item;
  logic                  m_valid;
  gppmi_pkg::result_t    res_q;
  gppmi_pkg::result_t    res;
  gppmi_pkg::update_t    upd;
  gppmi_pkg::port_view_t view;
  logic [7:0]            prev;
  logic [7:0]            prio [gppmi_pkg::MAX_PORTS];
  logic                  advance;
  logic                  port_ok;

  // Input stage moves forward when the result register is free or being drained
  assign advance       = in_valid && (!m_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign port_ok       = ({1'b0, in_item.port} < 3'(NUM_PORTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.operation  <= s_axis_tuser[1:0];
      in_item.port       <= s_axis_tuser[3:2];
      in_item.reg_select <= s_axis_tuser[6:4];
      in_item.data       <= s_axis_tdata;
    end
  end

  // Priority bits, one byte per port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < gppmi_pkg::MAX_PORTS; p++) begin
        prio[p] <= '0;
      end
    end else if (cfg_wen) begin
      prio[cfg_index] <= cfg_wdata;
    end
  end

  gppmi_regs #(
    .NUM_PORTS (NUM_PORTS),
    .PIW       (PIW)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .port_idx (in_item.port[PIW-1:0]),
    .commit   (advance),
    .upd      (upd),
    .view     (view),
    .prev     (prev)
  );

  gppmi_exec u_exec (
    .item    (in_item),
    .port_ok (port_ok),
    .view    (view),
    .prev    (prev),
    .prio    (prio[in_item.port]),
    .res     (res),
    .upd     (upd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'b0, res_q.ack_request, res_q.irq_vector, res_q.irq_valid,
                          res_q.pin_result, res_q.read_data};

  // A held input beat must not vanish while the result side is stalled
  `GPPMI_ASSERT_NEXT(a_hold_input, in_valid && !advance, in_valid, "input beat dropped")
  // A raised interrupt always carries a vector in the 0x80..0xFF range
  `GPPMI_ASSERT(a_irq_vec, m_valid && res_q.irq_valid |-> res_q.irq_vector[7], "bad vector")
  // Only pin updates raise interrupts
  `GPPMI_ASSERT_NEXT(a_irq_src, advance && in_item.operation != gppmi_pkg::OP_PIN,
                     !res_q.irq_valid && res_q.irq_vector == 8'h00, "irq from non-pin beat")
  // Only register writes request an acknowledge
  `GPPMI_ASSERT_NEXT(a_ack_src, advance && in_item.operation != gppmi_pkg::OP_WRITE,
                     !res_q.ack_request, "ack from non-write beat")

endmodule
